[sv/fdl_pkg.sv]
// Shared types, constants and arithmetic helpers for the feedback delay lowpass.
`timescale 1ns / 1ps

package fdl_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int ADDR_WIDTH   = 16;
   localparam int DELAY_DEPTH  = 1 << ADDR_WIDTH;
   localparam int LEN_WIDTH    = 16;
   localparam int COEF_WIDTH   = 16;
   localparam int MIX_WIDTH    = 17;
   localparam int CSR_WIDTH    = 17;
   localparam int CSR_IDX_WIDTH = 2;

   // full-precision product and its rounded Q16 quotient
   localparam int PROD_WIDTH  = SAMPLE_WIDTH + 18;
   localparam int ROUND_WIDTH = PROD_WIDTH - 16;

   localparam logic [MIX_WIDTH-1:0]  COEF_ONE    = 17'd65536;
   localparam logic [COEF_WIDTH-1:0] COEF_WARM   = 16'd10486;
   localparam logic [COEF_WIDTH-1:0] COEF_BRIGHT = 16'd26870;

   localparam logic [COEF_WIDTH-1:0] REGEN_RESET = 16'd0;
   localparam logic [LEN_WIDTH-1:0]  LEN_RESET   = 16'd882;
   localparam logic [MIX_WIDTH-1:0]  MIX_RESET   = 17'd32768;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_REGEN_GAIN   = 2'd0,
      CSR_DELAY_LENGTH = 2'd1,
      CSR_MIX_LEVEL    = 2'd2,
      CSR_WARM_MODE    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_REGEN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;       // capture dry word
      logic mult;       // register mix and filter products
      logic sum;        // register wet word and new filter value
      logic regen;      // register feedback product
      logic clear;      // zero the filter memory
      logic line_full;  // store entry at the read position holds valid data
   } ctrl_type;

   typedef struct packed {
      logic [MIX_WIDTH-1:0]  mix;
      logic [COEF_WIDTH-1:0] alpha;
      logic [COEF_WIDTH-1:0] regen;
   } coef_type;

   localparam logic signed [ROUND_WIDTH-1:0] SAT_HI =
      ROUND_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [ROUND_WIDTH-1:0] SAT_LO = -SAT_HI - ROUND_WIDTH'(1);

   // (x + 32768) / 65536, floored
   function automatic logic signed [ROUND_WIDTH-1:0] round_q16(
      input logic signed [PROD_WIDTH-1:0] x);
      logic signed [PROD_WIDTH-1:0] biased;
      biased = x + PROD_WIDTH'(32768);
      return biased[PROD_WIDTH-1:16];
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [ROUND_WIDTH-1:0] x);
      logic signed [ROUND_WIDTH-1:0] y;
      if (x > SAT_HI) begin
         y = SAT_HI;
      end else if (x < SAT_LO) begin
         y = SAT_LO;
      end else begin
         y = x;
      end
      return y[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

[sv/fdl_delay_ram.sv]
// Single-port delay store with registered read data.
`timescale 1ns / 1ps

module fdl_delay_ram (
   input  logic                                clock,
   input  logic                                read_enable,
   input  logic                                write_enable,
   input  logic [fdl_pkg::ADDR_WIDTH-1:0]      addr,
   input  logic [fdl_pkg::SAMPLE_WIDTH-1:0]    write_data,
   output logic [fdl_pkg::SAMPLE_WIDTH-1:0]    read_data
);

   logic [fdl_pkg::SAMPLE_WIDTH-1:0] mem [fdl_pkg::DELAY_DEPTH];
   logic [fdl_pkg::SAMPLE_WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

[sv/fdl_datapath.sv]
// Mix, one-pole lowpass and feedback arithmetic for one sample.
`timescale 1ns / 1ps

module fdl_datapath (
   input  logic                                     clock,
   input  fdl_pkg::ctrl_type                        ctrl,
   input  fdl_pkg::coef_type                        coef,
   input  logic signed [fdl_pkg::SAMPLE_WIDTH-1:0]  dry_sample,
   input  logic [fdl_pkg::SAMPLE_WIDTH-1:0]         mem_rdata,
   output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0]  wet_sample,
   output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0]  stored_sample
);

   localparam int PW = fdl_pkg::PROD_WIDTH;
   localparam int SW = fdl_pkg::SAMPLE_WIDTH;
   localparam int RW = fdl_pkg::ROUND_WIDTH;

   logic signed [SW-1:0] dry_ff;
   logic signed [SW-1:0] filt_ff;
   logic signed [SW-1:0] filt_in;
   logic signed [SW-1:0] wet_ff;
   logic signed [SW-1:0] wet_in;
   logic signed [SW-1:0] delayed;

   logic signed [PW-1:0] p_dry_ff, p_dry_in;
   logic signed [PW-1:0] p_wet_ff, p_wet_in;
   logic signed [PW-1:0] p_new_ff, p_new_in;
   logic signed [PW-1:0] p_old_ff, p_old_in;
   logic signed [PW-1:0] p_regen_ff, p_regen_in;

   logic signed [17:0] mix_s, dry_gain_s, new_gain_s, old_gain_s;
   logic signed [17:0] regen_s;
   logic [fdl_pkg::MIX_WIDTH-1:0] dry_gain;
   logic [fdl_pkg::MIX_WIDTH-1:0] new_gain;

   // entries not yet written since the last clear read as zero
   assign delayed = ctrl.line_full ? $signed(mem_rdata) : '0;

   always_comb begin
      dry_gain   = fdl_pkg::COEF_ONE - coef.mix;
      new_gain   = fdl_pkg::COEF_ONE - fdl_pkg::MIX_WIDTH'(coef.alpha);
      mix_s      = $signed({1'b0, coef.mix});
      dry_gain_s = $signed({1'b0, dry_gain});
      new_gain_s = $signed({1'b0, new_gain});
      old_gain_s = $signed({2'b00, coef.alpha});
      regen_s    = $signed({2'b00, coef.regen});

      p_wet_in   = PW'(mix_s) * PW'(delayed);
      p_dry_in   = PW'(dry_gain_s) * PW'(dry_ff);
      p_new_in   = PW'(new_gain_s) * PW'(delayed);
      p_old_in   = PW'(old_gain_s) * PW'(filt_ff);
      p_regen_in = PW'(regen_s) * PW'(filt_ff);

      wet_in  = fdl_pkg::sat_sample(fdl_pkg::round_q16(p_wet_ff + p_dry_ff));
      filt_in = fdl_pkg::sat_sample(fdl_pkg::round_q16(p_new_ff + p_old_ff));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         dry_ff <= dry_sample;
      end
      if (ctrl.mult) begin
         p_wet_ff <= p_wet_in;
         p_dry_ff <= p_dry_in;
         p_new_ff <= p_new_in;
         p_old_ff <= p_old_in;
      end
      if (ctrl.sum) begin
         wet_ff <= wet_in;
      end
      if (ctrl.regen) begin
         p_regen_ff <= p_regen_in;
      end
   end

   // filter memory is state and clears on reset and on a delay_length write
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         filt_ff <= '0;
      end else if (ctrl.sum) begin
         filt_ff <= filt_in;
      end
   end

   assign wet_sample    = wet_ff;
   assign stored_sample = fdl_pkg::sat_sample(RW'(dry_ff) + fdl_pkg::round_q16(p_regen_ff));

endmodule

[sv/feedback_delay_lowpass.sv]
// Top level: register file, sequencer and output register of the echo.
`timescale 1ns / 1ps

// Feedback echo with a one-pole lowpass in the feedback path. Each sample word runs
// accept and store read, product stage, rounding and filter update, feedback product,
// then store write-back and output load, held while the output stalls; the single store
// port and the two multiply stages set these steps, and one sample is in flight at a
// time. A finished word waits in the output register while the next sample is accepted.
// Writing delay_length restarts the line: position, filter and store read back as zero
// at once, since entries are only returned once the write position has wrapped, so no
// clearing pass is needed after reset or a length change. Configure only while idle.
module feedback_delay_lowpass (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [fdl_pkg::SAMPLE_WIDTH-1:0]   req_dry_sample,
   input  logic                                      req_block_last,

   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0]   rsp_wet_sample,
   output logic                                      rsp_block_last_out,

   input  logic                                      csr_write_enable,
   input  logic [fdl_pkg::CSR_IDX_WIDTH-1:0]         csr_index,
   input  logic [fdl_pkg::CSR_WIDTH-1:0]             csr_write_data
);

   localparam int AW = fdl_pkg::ADDR_WIDTH;
   localparam int LW = fdl_pkg::LEN_WIDTH;

   fdl_pkg::state_type state_ff, state_in;
   fdl_pkg::ctrl_type  ctrl;
   fdl_pkg::coef_type  coef;

   logic [fdl_pkg::COEF_WIDTH-1:0] regen_ff;
   logic [LW-1:0]                  length_ff;
   logic [fdl_pkg::MIX_WIDTH-1:0]  mix_ff;
   logic                           warm_ff;

   logic [AW-1:0] pos_ff, pos_in;
   logic          full_ff, full_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] rsp_wet_ff;
   logic          rsp_last_ff;
   logic          last_ff;

   logic [LW-1:0] eff_length;
   logic [LW:0]   pos_inc;
   logic          accept;
   logic          out_free;
   logic          write_back;
   logic          length_write;

   logic [fdl_pkg::SAMPLE_WIDTH-1:0]        mem_rdata;
   logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] wet_sample;
   logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] stored_sample;

   // ---------------------------------------------------------------- registers
   assign length_write = csr_write_enable &&
                         (fdl_pkg::csr_index_type'(csr_index) == fdl_pkg::CSR_DELAY_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         regen_ff  <= fdl_pkg::REGEN_RESET;
         length_ff <= fdl_pkg::LEN_RESET;
         mix_ff    <= fdl_pkg::MIX_RESET;
         warm_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (fdl_pkg::csr_index_type'(csr_index))
            fdl_pkg::CSR_REGEN_GAIN:   regen_ff  <= csr_write_data[fdl_pkg::COEF_WIDTH-1:0];
            fdl_pkg::CSR_DELAY_LENGTH: length_ff <= csr_write_data[LW-1:0];
            fdl_pkg::CSR_MIX_LEVEL:    mix_ff    <= csr_write_data[fdl_pkg::MIX_WIDTH-1:0];
            fdl_pkg::CSR_WARM_MODE:    warm_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign eff_length = (length_ff == '0) ? LW'(1) : length_ff;

   always_comb begin
      coef.mix   = (mix_ff > fdl_pkg::COEF_ONE) ? fdl_pkg::COEF_ONE : mix_ff;
      coef.alpha = warm_ff ? fdl_pkg::COEF_WARM : fdl_pkg::COEF_BRIGHT;
      coef.regen = regen_ff;
   end

   // ---------------------------------------------------------------- sequencer
   assign accept     = req_valid && (state_ff == fdl_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign write_back = (state_ff == fdl_pkg::ST_WRITE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fdl_pkg::ST_IDLE:  if (req_valid) state_in = fdl_pkg::ST_MULT;
         fdl_pkg::ST_MULT:  state_in = fdl_pkg::ST_SUM;
         fdl_pkg::ST_SUM:   state_in = fdl_pkg::ST_REGEN;
         fdl_pkg::ST_REGEN: state_in = fdl_pkg::ST_WRITE;
         fdl_pkg::ST_WRITE: if (out_free) state_in = fdl_pkg::ST_IDLE;
         default:           state_in = fdl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.clear     = reset || length_write;
      ctrl.line_full = full_ff;
      unique case (state_ff)
         fdl_pkg::ST_IDLE:  ctrl.load  = req_valid;
         fdl_pkg::ST_MULT:  ctrl.mult  = 1'b1;
         fdl_pkg::ST_SUM:   ctrl.sum   = 1'b1;
         fdl_pkg::ST_REGEN: ctrl.regen = 1'b1;
         fdl_pkg::ST_WRITE: ;
         default: ;
      endcase
   end

   assign req_stall = (state_ff != fdl_pkg::ST_IDLE);

   // ---------------------------------------------------------------- position
   assign pos_inc = {1'b0, pos_ff} + (LW + 1)'(1);

   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      if (ctrl.clear) begin
         pos_in  = '0;
         full_in = 1'b0;
      end else if (write_back) begin
         if (pos_inc >= {1'b0, eff_length}) begin
            pos_in  = '0;
            full_in = 1'b1;
         end else begin
            pos_in = pos_inc[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= reset ? fdl_pkg::ST_IDLE : state_in;
      pos_ff   <= pos_in;
      full_ff  <= full_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_block_last;
      end
   end

   // ---------------------------------------------------------------- output word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (write_back) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= reset ? 1'b0 : rsp_valid_in;
      if (write_back) begin
         rsp_wet_ff  <= wet_sample;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_wet_sample     = rsp_wet_ff;
   assign rsp_block_last_out = rsp_last_ff;

   // ---------------------------------------------------------------- units
   fdl_delay_ram u_ram (
      .clock        (clock),
      .read_enable  (accept),
      .write_enable (write_back),
      .addr         (pos_ff),
      .write_data   (stored_sample),
      .read_data    (mem_rdata)
   );

   fdl_datapath u_datapath (
      .clock         (clock),
      .ctrl          (ctrl),
      .coef          (coef),
      .dry_sample    (req_dry_sample),
      .mem_rdata     (mem_rdata),
      .wet_sample    (wet_sample),
      .stored_sample (stored_sample)
   );

endmodule
